// File: sv/srvr_pkg.sv
package srvr_pkg;

   localparam int VEL_W   = 32;
   localparam int STEP_W  = 20;
   localparam int BAND_W  = 31;
   localparam int DWELL_W = 16;
   localparam int PHASE_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;

   localparam logic [STEP_W-1:0]  RAMP_STEP_RESET   = 20'd1000;
   localparam logic [BAND_W-1:0]  DEADBAND_RESET    = 31'd100;
   localparam logic [DWELL_W-1:0] DWELL_TICKS_RESET = 16'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DWELL_TICKS = 2'd2;

   localparam logic CMD_TARGET = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [PHASE_W-1:0] PHASE_DIRECT  = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_TO_ZERO = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_TO_GOAL = 2'd2;

   typedef enum logic [2:0] {
      RP_IDLE,
      RP_STOP,
      RP_DOWN,
      RP_DWELL,
      RP_UP
   } ramp_phase_type;

endpackage

// File: sv/srvr_req_if.sv
interface srvr_req_if import srvr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    command;
   logic signed [VEL_W-1:0] target_velocity;
   logic signed [VEL_W-1:0] actual_velocity;
   logic                    actual_valid;

   modport source (
      output valid, command, target_velocity, actual_velocity, actual_valid,
      input  ready
   );
   modport sink (
      input  valid, command, target_velocity, actual_velocity, actual_valid,
      output ready
   );
endinterface

// File: sv/srvr_rsp_if.sv
interface srvr_rsp_if import srvr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VEL_W-1:0] setpoint;
   logic [PHASE_W-1:0]      phase;
   logic                    final_res;

   modport source (
      output valid, setpoint, phase, final_res,
      input  ready
   );
   modport sink (
      input  valid, setpoint, phase, final_res,
      output ready
   );
endinterface

// File: sv/safe_reverse_velocity_ramp_unit.sv
// A request is registered on acceptance; its setpoint then moves to the response
// register once that is free or being read. Throughput: one request per cycle while
// the response side does not stall; the ramp state updates in one pass.
// Ticks that idle or hold zero give no response.
// Reset (synchronous, active high) clears the ramp state and the valid flags
// and loads the register defaults (step 1000, deadband 100, dwell 10).
module safe_reverse_velocity_ramp_unit import srvr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   srvr_req_if.sink              req_if,
   srvr_rsp_if.source            rsp_if,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam logic [VEL_W-1:0] SIGN_BIT = {1'b1, {(VEL_W-1){1'b0}}};

   function automatic logic [VEL_W-1:0] sat_in(input logic [VEL_W-1:0] v);
      sat_in = (v == SIGN_BIT) ? (SIGN_BIT + 1'b1) : v;
   endfunction

   function automatic logic [VEL_W-1:0] mag(input logic [VEL_W-1:0] v);
      mag = v[VEL_W-1] ? ({VEL_W{1'b0}} - v) : v;
   endfunction

   // configuration
   logic [STEP_W-1:0]  ramp_step_ff;
   logic [BAND_W-1:0]  deadband_ff;
   logic [DWELL_W-1:0] dwell_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_step_ff   <= RAMP_STEP_RESET;
         deadband_ff    <= DEADBAND_RESET;
         dwell_ticks_ff <= DWELL_TICKS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RAMP_STEP:   ramp_step_ff   <= csr_write_data[STEP_W-1:0];
            CSR_DEADBAND:    deadband_ff    <= csr_write_data[BAND_W-1:0];
            CSR_DWELL_TICKS: dwell_ticks_ff <= csr_write_data[DWELL_W-1:0];
            default: ;
         endcase
      end
   end

   // request register
   logic             req_valid_ff;
   logic             cmd_ff;
   logic [VEL_W-1:0] target_ff;
   logic [VEL_W-1:0] actual_ff;
   logic             actual_valid_ff;

   // response register
   logic               rsp_valid_ff;
   logic [VEL_W-1:0]   setpoint_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic               final_ff;

   logic stage_fire;
   assign stage_fire    = req_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !req_valid_ff || stage_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         req_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         cmd_ff          <= req_if.command;
         target_ff       <= req_if.target_velocity;
         actual_ff       <= req_if.actual_velocity;
         actual_valid_ff <= req_if.actual_valid;
      end
   end

   // ramp state
   ramp_phase_type     ramp_phase_ff, ramp_phase_in;
   logic [VEL_W-1:0]   last_ff, last_in;
   logic [VEL_W-1:0]   goal_ff, goal_in;
   logic [DWELL_W-1:0] dwell_ff, dwell_in;

   logic [VEL_W-1:0]   target, actual, start, smag, base;
   logic [VEL_W-1:0]   step, zmag, tz, gmag, tg;
   logic [VEL_W:0]     gsum;
   logic               is_tick, reverse, zero_stop;
   ramp_phase_type     sel;
   logic               emit;
   logic [VEL_W-1:0]   out_v;
   logic [PHASE_W-1:0] out_ph;
   logic               out_fin;

   always_comb begin
      is_tick = (cmd_ff == CMD_TICK);
      target  = sat_in(target_ff);
      actual  = sat_in(actual_ff);
      start   = (actual_valid_ff && (mag(actual) > mag(last_ff))) ? actual : last_ff;
      smag    = mag(start);

      reverse = (start != '0) && (target != '0) && (start[VEL_W-1] != target[VEL_W-1])
                && (smag > {1'b0, deadband_ff});
      zero_stop = (target == '0) && (smag > {1'b0, deadband_ff});

      step = {{(VEL_W-STEP_W){1'b0}},
              (ramp_step_ff == '0) ? {{(STEP_W-1){1'b0}}, 1'b1} : ramp_step_ff};

      base = is_tick ? last_ff : start;
      zmag = (mag(base) <= step) ? '0 : (mag(base) - step);
      tz   = base[VEL_W-1] ? ({VEL_W{1'b0}} - zmag) : zmag;

      gsum = {1'b0, mag(last_ff)} + {1'b0, step};
      gmag = (gsum > {1'b0, mag(goal_ff)}) ? mag(goal_ff) : gsum[VEL_W-1:0];
      tg   = goal_ff[VEL_W-1] ? ({VEL_W{1'b0}} - gmag) : gmag;

      last_in  = last_ff;
      goal_in  = goal_ff;
      dwell_in = dwell_ff;
      emit     = 1'b0;
      out_v    = tz;
      out_ph   = PHASE_DIRECT;
      out_fin  = 1'b0;

      if (is_tick) begin
         sel = ramp_phase_ff;
      end else begin
         dwell_in = '0;
         if (reverse) begin
            sel     = RP_DOWN;
            goal_in = target;
         end else if (zero_stop) begin
            sel     = RP_STOP;
            goal_in = '0;
         end else begin
            sel     = RP_IDLE;
            goal_in = target;
         end
      end
      ramp_phase_in = sel;

      case (sel)
         RP_STOP: begin
            emit    = 1'b1;
            out_ph  = PHASE_TO_ZERO;
            out_fin = (tz == '0);
            if (tz == '0) ramp_phase_in = RP_IDLE;
         end
         RP_DOWN: begin
            emit   = 1'b1;
            out_ph = PHASE_TO_ZERO;
            if (tz == '0) begin
               if (dwell_ticks_ff == '0) begin
                  ramp_phase_in = RP_UP;
               end else begin
                  ramp_phase_in = RP_DWELL;
                  dwell_in      = dwell_ticks_ff;
               end
            end
         end
         RP_DWELL: begin
            dwell_in = dwell_ff - 1'b1;
            if (dwell_in == '0) ramp_phase_in = RP_UP;
         end
         RP_UP: begin
            emit    = 1'b1;
            out_v   = tg;
            out_ph  = PHASE_TO_GOAL;
            out_fin = (tg == goal_ff);
            if (tg == goal_ff) ramp_phase_in = RP_IDLE;
         end
         default: begin
            ramp_phase_in = RP_IDLE;
            if (!is_tick) begin
               emit    = 1'b1;
               out_v   = target;
               out_ph  = PHASE_DIRECT;
               out_fin = 1'b1;
            end
         end
      endcase

      if (emit) last_in = out_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_phase_ff <= RP_IDLE;
         last_ff       <= '0;
         goal_ff       <= '0;
         dwell_ff      <= '0;
      end else if (stage_fire) begin
         ramp_phase_ff <= ramp_phase_in;
         last_ff       <= last_in;
         goal_ff       <= goal_in;
         dwell_ff      <= dwell_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_fire) begin
         rsp_valid_ff <= emit;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_fire && emit) begin
         setpoint_ff <= out_v;
         phase_ff    <= out_ph;
         final_ff    <= out_fin;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.setpoint  = setpoint_ff;
   assign rsp_if.phase     = phase_ff;
   assign rsp_if.final_res = final_ff;

endmodule

// File: sv/srvr_checker.sv
module srvr_checker import srvr_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [VEL_W-1:0]   rsp_setpoint,
   input logic [PHASE_W-1:0] rsp_phase,
   input logic               rsp_final_res
);

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_direct_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase == PHASE_DIRECT) |-> rsp_final_res)
      else $error("direct write not marked final");

   a_stop_ends_at_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase == PHASE_TO_ZERO) && rsp_final_res |-> rsp_setpoint == '0)
      else $error("ramp to zero finished away from zero");

   a_ramp_up_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase == PHASE_TO_GOAL) |-> rsp_setpoint != '0)
      else $error("ramp toward target emitted zero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_setpoint))
      else $error("stalled response changed");

endmodule

bind safe_reverse_velocity_ramp_unit srvr_checker u_srvr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_setpoint  (rsp_if.setpoint),
   .rsp_phase     (rsp_if.phase),
   .rsp_final_res (rsp_if.final_res)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import srvr_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned LONG_HOLD    = 150;
   localparam int unsigned RANDOM_ITEMS = 1200;
   localparam int unsigned PHASES       = 8;

   typedef struct packed {
      logic [VEL_W-1:0]   setpoint;
      logic [PHASE_W-1:0] phase;
      logic               final_res;
   } setpoint_rec_type;

   typedef enum int unsigned {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   srvr_req_if req_bus ();
   srvr_rsp_if rsp_bus ();

   safe_reverse_velocity_ramp_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ramp predictor state
   logic [VEL_W-1:0]   sp_last;
   logic [VEL_W-1:0]   goal_vel;
   ramp_phase_type     rphase;
   logic [DWELL_W-1:0] dwell_left;
   logic [STEP_W-1:0]  cfg_step;
   logic [BAND_W-1:0]  cfg_band;
   logic [DWELL_W-1:0] cfg_dwell;

   setpoint_rec_type pending_setpoints[$];
   setpoint_rec_type oldest_setpoint;

   int unsigned  err_count;
   int unsigned  cycle_count;
   int unsigned  work_items;
   int unsigned  burst_left;
   bit           sender_bursty;
   bit           hold_pending;
   int unsigned  hold_left;
   int unsigned  mode_left;
   rx_style_type rx_style;
   logic [7:0]   rx_pattern;

   function automatic logic [VEL_W-1:0] mag(input logic [VEL_W-1:0] v);
      return v[VEL_W-1] ? -v : v;
   endfunction

   function automatic logic [VEL_W-1:0] eff_step();
      return (cfg_step == '0) ? 32'd1 : {{(VEL_W-STEP_W){1'b0}}, cfg_step};
   endfunction

   function automatic logic [VEL_W-1:0] clamp_min(input logic [VEL_W-1:0] v);
      return (v == 32'h8000_0000) ? 32'h8000_0001 : v;
   endfunction

   function automatic logic [VEL_W-1:0] shrink_toward_zero(input logic [VEL_W-1:0] v);
      logic [VEL_W-1:0] m;
      m = mag(v);
      m = (m <= eff_step()) ? '0 : m - eff_step();
      return v[VEL_W-1] ? -m : m;
   endfunction

   function automatic void push_setpoint(input logic [VEL_W-1:0] v,
                                         input logic [PHASE_W-1:0] ph, input logic fin);
      sp_last = v;
      pending_setpoints.push_back('{setpoint: v, phase: ph, final_res: fin});
   endfunction

   function automatic void advance_ramp(input logic [VEL_W-1:0] base);
      logic [VEL_W-1:0] v;
      logic [VEL_W:0]   grown;
      logic [VEL_W-1:0] m;
      case (rphase)
         RP_STOP: begin
            v = shrink_toward_zero(base);
            if (v == '0) rphase = RP_IDLE;
            push_setpoint(v, PHASE_TO_ZERO, v == '0);
         end
         RP_DOWN: begin
            v = shrink_toward_zero(base);
            if (v == '0) begin
               if (cfg_dwell == '0) begin
                  rphase = RP_UP;
               end else begin
                  dwell_left = cfg_dwell;
                  rphase = RP_DWELL;
               end
            end
            push_setpoint(v, PHASE_TO_ZERO, 1'b0);
         end
         RP_DWELL: begin
            dwell_left = dwell_left - 1'b1;
            if (dwell_left == '0) rphase = RP_UP;
         end
         RP_UP: begin
            grown = {1'b0, mag(base)} + {1'b0, eff_step()};
            m = (grown > {1'b0, mag(goal_vel)}) ? mag(goal_vel) : grown[VEL_W-1:0];
            v = goal_vel[VEL_W-1] ? -m : m;
            if (v == goal_vel) rphase = RP_IDLE;
            push_setpoint(v, PHASE_TO_GOAL, v == goal_vel);
         end
         default: rphase = RP_IDLE;
      endcase
   endfunction

   function automatic void predict_request(input logic cmd, input logic [VEL_W-1:0] tgt_raw,
                                           input logic [VEL_W-1:0] act_raw, input logic av);
      logic [VEL_W-1:0] tgt;
      logic [VEL_W-1:0] act;
      logic [VEL_W-1:0] start;
      logic [VEL_W-1:0] smag;
      logic             reversing;
      if (cmd == CMD_TICK) begin
         advance_ramp(sp_last);
         return;
      end
      tgt = clamp_min(tgt_raw);
      act = clamp_min(act_raw);
      start = sp_last;
      if (av && mag(act) > mag(start)) start = act;
      smag = mag(start);
      reversing = (start != '0) && (tgt != '0) && (start[VEL_W-1] != tgt[VEL_W-1]) &&
                  (smag > {1'b0, cfg_band});
      dwell_left = '0;
      if (reversing) begin
         goal_vel = tgt;
         rphase = RP_DOWN;
         advance_ramp(start);
      end else if (tgt == '0 && smag > {1'b0, cfg_band}) begin
         goal_vel = '0;
         rphase = RP_STOP;
         advance_ramp(start);
      end else begin
         goal_vel = tgt;
         rphase = RP_IDLE;
         push_setpoint(tgt, PHASE_DIRECT, 1'b1);
      end
   endfunction

   function automatic logic [VEL_W-1:0] pick_velocity();
      logic [63:0]      span;
      logic [VEL_W-1:0] m;
      case ($urandom_range(0, 9))
         0: return '0;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h8000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         2, 3: return $urandom;
         default: begin
            span = 64'(eff_step()) * $urandom_range(1, 8) + 64'(cfg_band) + 64'd1;
            if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
            m = $urandom_range(0, span[31:0]);
            return $urandom_range(0, 1) ? -m : m;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [VEL_W-1:0] want,
                                  input logic [VEL_W-1:0] got);
      $display("mismatch %s: expected %0h got %0h (cycle %0d)", what, want, got, cycle_count);
      err_count++;
   endtask

   task automatic send_req(input logic cmd, input logic [VEL_W-1:0] tgt,
                           input logic [VEL_W-1:0] act, input logic av);
      req_bus.valid           <= 1'b1;
      req_bus.command         <= cmd;
      req_bus.target_velocity <= tgt;
      req_bus.actual_velocity <= act;
      req_bus.actual_valid    <= av;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (cmd == CMD_TARGET || rphase != RP_IDLE) work_items++;
      predict_request(cmd, tgt, act, av);
      if (sender_bursty) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic tick_until_idle(input int unsigned cap);
      int unsigned n;
      n = 0;
      while (rphase != RP_IDLE && n < cap) begin
         send_req(CMD_TICK, $urandom, $urandom, 1'($urandom));
         n++;
      end
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_setpoints.size() != 0) @(posedge clock);
      // ticks that give no response may still be in flight
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_RAMP_STEP:   cfg_step  = data[STEP_W-1:0];
         CSR_DEADBAND:    cfg_band  = data[BAND_W-1:0];
         CSR_DWELL_TICKS: cfg_dwell = data[DWELL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [STEP_W-1:0] new_step,
                             input logic [BAND_W-1:0] new_band,
                             input logic [DWELL_W-1:0] new_dwell);
      wait_idle();
      write_csr(CSR_RAMP_STEP, CSR_DATA_W'(new_step));
      write_csr(CSR_DEADBAND, CSR_DATA_W'(new_band));
      write_csr(CSR_DWELL_TICKS, CSR_DATA_W'(new_dwell));
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_req(CMD_TICK, $urandom, $urandom, 1'b1);
      send_req(CMD_TARGET, 32'd2500, 32'd0, 1'b0);
      send_req(CMD_TARGET, -32'sd1200, 32'd0, 1'b1);
      tick_until_idle(40);
      send_req(CMD_TICK, $urandom, $urandom, 1'b0);
      send_req(CMD_TARGET, 32'd0, 32'd0, 1'b0);
      tick_until_idle(40);
      send_req(CMD_TARGET, 32'd0, 32'd50, 1'b1);
      send_req(CMD_TARGET, 32'd0, -32'sd101, 1'b1);
      tick_until_idle(40);
   endtask

   task automatic test_zero_dwell_and_step();
      set_config(20'd0, 31'd0, 16'd0);
      send_req(CMD_TARGET, 32'd3, 32'd0, 1'b0);
      send_req(CMD_TARGET, -32'sd2, 32'd0, 1'b0);
      tick_until_idle(20);
   endtask

   task automatic test_extremes_and_restart();
      set_config(20'hF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
      send_req(CMD_TARGET, 32'h8000_0000, 32'd0, 1'b0);
      send_req(CMD_TARGET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_req(CMD_TARGET, 32'd0, 32'h8000_0000, 1'b1);
      set_config(20'hF_FFFF, 31'd0, 16'hFFFF);
      send_req(CMD_TARGET, 32'h7FFF_FFFF, 32'd0, 1'b0);
      send_req(CMD_TARGET, 32'h8000_0000, 32'd0, 1'b0);
      repeat (3) send_req(CMD_TICK, $urandom, $urandom, 1'b1);
      send_req(CMD_TARGET, 32'd0, 32'd0, 1'b0);
      repeat (2) send_req(CMD_TICK, $urandom, $urandom, 1'b0);
      send_req(CMD_TARGET, -32'sd7, 32'd0, 1'b0);
      send_req(CMD_TARGET, 32'd5, 32'h8000_0000, 1'b0);
      send_req(CMD_TARGET, -32'sd5, 32'd0, 1'b0);
      repeat (3) send_req(CMD_TICK, $urandom, $urandom, 1'b1);
      send_req(CMD_TARGET, 32'd9, 32'd0, 1'b0);
   endtask

   task automatic test_measured_velocity();
      set_config(20'd40, 31'd50, 16'd2);
      send_req(CMD_TARGET, 32'd30, 32'd200, 1'b1);
      send_req(CMD_TARGET, -32'sd30, 32'd200, 1'b1);
      tick_until_idle(20);
      send_req(CMD_TARGET, -32'sd20, 32'd50, 1'b1);
      send_req(CMD_TARGET, 32'd20, -32'sd99999, 1'b0);
   endtask

   task automatic test_backpressure();
      set_config(20'd1000, 31'd100, 16'd3);
      sender_bursty = 1'b0;
      hold_pending = 1'b1;
      repeat (40) send_req(CMD_TARGET, pick_velocity(), pick_velocity(), 1'($urandom));
      sender_bursty = 1'b1;
   endtask

   task automatic test_random_ramps();
      int unsigned phase_end;
      for (int unsigned ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: set_config(20'd1000, 31'd100, 16'd10);
            1: set_config(20'd0, 31'd0, 16'd0);
            2: set_config(20'hF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
            3: set_config(20'hF_FFFF, 31'd0, 16'd0);
            4: set_config(20'd1, 31'd0, 16'd1);
            5: set_config(20'($urandom_range(1, 5000)), 31'($urandom_range(0, 2000)),
                          16'($urandom_range(1, 6)));
            6: set_config(20'd50000, 31'd10, 16'hFFFF);
            default: set_config(20'($urandom), 31'($urandom_range(0, 100000)),
                                16'($urandom_range(0, 3)));
         endcase
         phase_end = work_items + RANDOM_ITEMS / PHASES;
         while (work_items < phase_end) begin
            sender_bursty = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
               send_req(CMD_TICK, $urandom, $urandom, 1'($urandom));
            end else begin
               send_req(CMD_TARGET, pick_velocity(), pick_velocity(), 1'($urandom));
               if ($urandom_range(0, 4) == 0) tick_until_idle($urandom_range(0, 6));
               else tick_until_idle(48);
               if ($urandom_range(0, 3) == 0)
                  repeat ($urandom_range(1, 2)) send_req(CMD_TICK, $urandom, $urandom, 1'($urandom));
            end
         end
      end
      sender_bursty = 1'b1;
   endtask

   // response side: stall styles are picked at random, with a long hold on request
   initial begin
      rsp_bus.ready = 1'b0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            for (hold_left = LONG_HOLD; hold_left != 0; hold_left--) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               rx_style   = rx_style_type'($urandom_range(0, 2));
               rx_pattern = 8'($urandom) | 8'h01;
               mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (rx_style)
               RX_ALWAYS: rsp_bus.ready <= 1'b1;
               RX_RANDOM: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               default:   rsp_bus.ready <= rx_pattern[mode_left % 8];
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_setpoints.size() == 0) begin
            report_mismatch("response with none pending", '0, rsp_bus.setpoint);
         end else begin
            oldest_setpoint = pending_setpoints.pop_front();
            if (rsp_bus.setpoint !== oldest_setpoint.setpoint)
               report_mismatch("setpoint", oldest_setpoint.setpoint, rsp_bus.setpoint);
            if (rsp_bus.phase !== oldest_setpoint.phase)
               report_mismatch("phase", 32'(oldest_setpoint.phase), 32'(rsp_bus.phase));
            if (rsp_bus.final_res !== oldest_setpoint.final_res)
               report_mismatch("final_res", 32'(oldest_setpoint.final_res),
                               32'(rsp_bus.final_res));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset                   = 1'b1;
      csr_write_enable        = 1'b0;
      csr_index               = '0;
      csr_write_data          = '0;
      req_bus.valid           = 1'b0;
      req_bus.command         = CMD_TARGET;
      req_bus.target_velocity = '0;
      req_bus.actual_velocity = '0;
      req_bus.actual_valid    = 1'b0;
      err_count     = 0;
      cycle_count   = 0;
      work_items    = 0;
      burst_left    = 0;
      sender_bursty = 1'b1;
      hold_pending  = 1'b0;
      sp_last    = '0;
      goal_vel   = '0;
      rphase     = RP_IDLE;
      dwell_left = '0;
      cfg_step   = RAMP_STEP_RESET;
      cfg_band   = DEADBAND_RESET;
      cfg_dwell  = DWELL_TICKS_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_zero_dwell_and_step();
      test_extremes_and_restart();
      test_measured_velocity();
      test_backpressure();
      test_random_ramps();
      wait_idle();
      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
